### rtl/core/pga_pkg.sv
// Shared types and constants for the polar polygon area unit.
// Holds field widths, the controller state type, the unit status struct and
// the elaboration-time sine function. No dependencies.
`default_nettype none

package pga_pkg;

  localparam int unsigned LEN_W       = 10;
  localparam int unsigned ANG_W       = 9;
  localparam int unsigned AREA_W      = 26;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // scaled triangle magnitude and its constant divisor
  localparam int unsigned QW    = 29;
  localparam int unsigned REM_W = 8;
  localparam logic [REM_W:0] TRI_DIV = 9'd200;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIG,
    S_CX,
    S_CX_W,
    S_CY,
    S_CY_W,
    S_SETUP,
    S_P1,
    S_P1_W,
    S_P2,
    S_P2_W,
    S_DIFF,
    S_DIV_W,
    S_ADD,
    S_NEXT,
    S_EMIT
  } pga_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pga_unit_st_t;

  // sine of d degrees (0..90) as an unsigned fb-bit fraction, Taylor series at Q30
  function automatic logic [63:0] pga_sin_quarter(int unsigned d, int unsigned fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] lim;
    x    = (64'(d) * PI_Q30) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    pos  = '0;
    neg  = '0;
    for (int k = 0; k < 9; k++) begin
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      term = (term * x2) >> 30;
      term = term / 64'((2 * k + 2) * (2 * k + 3));
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    r   = (s + (64'd1 << (29 - fb))) >> (30 - fb);
    lim = (64'd1 << fb) - 64'd1;
    return (r > lim) ? lim : r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pga_mul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
// Depends on pga_pkg for the status struct.
`default_nettype none

module pga_mul import pga_pkg::*; #(
  parameter int unsigned WA = 25,
  parameter int unsigned WB = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   prod,
  output pga_unit_st_t       st
);

  localparam int unsigned CNT_W = $clog2(WB + 1);

  logic [WA+WB-1:0] acc_r;
  logic [WA-1:0]    a_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [WA:0]      hi_sum;

  always_comb begin
    hi_sum = {1'b0, acc_r[WA+WB-1:WB]} + (acc_r[0] ? {1'b0, a_r} : {(WA + 1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        acc_r  <= {{WA{1'b0}}, b};
        a_r    <= a;
        cnt_r  <= CNT_W'(WB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // add and shift right: one multiplier bit retired per cycle
        acc_r <= {hi_sum, acc_r[WB-1:1]};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;
  assign st   = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

### rtl/core/pga_div.sv
// Bit-serial restoring divider by the constant TRI_DIV, one quotient bit per cycle.
// Depends on pga_pkg for widths, the divisor and the status struct.
`default_nettype none

module pga_div import pga_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  output logic [QW-1:0] quotient,
  output pga_unit_st_t  st
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [QW-1:0]    sh_r;
  logic [REM_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [REM_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_r, sh_r[QW-1]};
    ge    = (trial >= TRI_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        sh_r   <= dividend;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift the dividend out the top, the quotient in at the bottom
        rem_r <= ge ? REM_W'(trial - TRI_DIV) : REM_W'(trial);
        sh_r  <= {sh_r[QW-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = sh_r;
  assign st       = '{busy: busy_r, done: done_r};

endmodule

`default_nettype wire

### rtl/core/polar_polygon_area_unit.sv
// Polar polygon area unit: sums triangle-fan areas of polar vertices.
// One vertex at a time: a shared shift-add multiplier forms the coordinates and the
// cross products, and a serial divider scales each triangle. The result waits in an
// output register.
// Reset (synchronous, active low) returns to idle awaiting a first vertex.
`default_nettype none

module polar_polygon_area_unit import pga_pkg::*; #(
  parameter int unsigned MAX_VERTICES   = 16,
  parameter int unsigned TRIG_FRAC_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // length_tenths[9:0], angle_deg[18:10], zero pad
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // area_q8[25:0], zero pad
);

  localparam int unsigned TFB   = TRIG_FRAC_BITS;
  localparam int unsigned CM    = LEN_W + TFB;
  localparam int unsigned CW    = CM + 1;
  localparam int unsigned PW    = 2 * CM + 1;
  localparam int unsigned DW    = 2 * CM + 2;
  localparam int unsigned SH    = 2 * TFB - 8;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [ANG_W-1:0] ANG_QTR  = ANG_W'(90);
  localparam logic [ANG_W-1:0] ANG_HALF = ANG_W'(180);
  localparam logic [ANG_W-1:0] ANG_3QTR = ANG_W'(270);
  localparam logic [ANG_W-1:0] ANG_FULL = ANG_W'(360);

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } pga_fold_t;

  logic [TFB-1:0] sin_tab [0:90];

  for (genvar gd = 0; gd <= 90; gd++) begin : g_sin
    assign sin_tab[gd] = TFB'(pga_sin_quarter(gd, TFB));
  end

  function automatic pga_fold_t fold(logic [ANG_W-1:0] a);
    pga_fold_t f;
    if (a <= ANG_QTR) begin
      f = '{neg: 1'b0, idx: 7'(a)};
    end else if (a <= ANG_HALF) begin
      f = '{neg: 1'b0, idx: 7'(ANG_HALF - a)};
    end else if (a <= ANG_3QTR) begin
      f = '{neg: 1'b1, idx: 7'(a - ANG_HALF)};
    end else begin
      f = '{neg: 1'b1, idx: 7'(ANG_FULL - a)};
    end
    return f;
  endfunction

  function automatic logic [CM-1:0] mag(logic [CW-1:0] v);
    return v[CW-1] ? CM'(-v) : CM'(v);
  endfunction

  function automatic logic [PW-1:0] sprod(logic [2*CM-1:0] m, logic neg);
    return neg ? -{1'b0, m} : {1'b0, m};
  endfunction

  pga_state_t state_r, state_nxt;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [ANG_W-1:0] ang_r, ang_nxt;
  logic             last_r, last_nxt;
  logic [TFB-1:0]   sin_mag_r, sin_mag_nxt, cos_mag_r, cos_mag_nxt;
  logic             sin_neg_r, sin_neg_nxt, cos_neg_r, cos_neg_nxt;
  logic [CW-1:0]    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0]    first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [CW-1:0]    prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic             psign_r, psign_nxt;
  logic [PW-1:0]    p1_r, p1_nxt;
  logic [DW-1:0]    diff_r, diff_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             in_poly_r, in_poly_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             close_r, close_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [AREA_W-1:0] out_data_r, out_data_nxt;

  logic             mul_start;
  logic [CM-1:0]    mul_a, mul_b;
  logic [2*CM-1:0]  mul_prod;
  pga_unit_st_t     mul_st;
  logic             div_start;
  logic [QW-1:0]    div_in, div_q;
  pga_unit_st_t     div_st;

  logic [ANG_W-1:0] ang_in;
  logic [ANG_W:0]   cos_sum;
  logic [ANG_W-1:0] cos_ang;
  pga_fold_t        sin_f, cos_f;
  logic [CW-1:0]    px, py, qx, qy, coord;
  logic [PW-1:0]    p2s;
  logic [DW-1:0]    absd;
  logic [SUM_W:0]   sum_ext;
  logic [CNT_W-1:0] cnt_inc;

  pga_mul #(.WA(CM), .WB(CM)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .st    (mul_st)
  );

  pga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .quotient (div_q),
    .st       (div_st)
  );

  always_comb begin
    ang_in  = in_tdata[LEN_W+ANG_W-1:LEN_W];
    cos_sum = {1'b0, ang_r} + {1'b0, ANG_QTR};
    cos_ang = (cos_sum >= {1'b0, ANG_FULL}) ? ANG_W'(cos_sum - {1'b0, ANG_FULL})
                                            : ANG_W'(cos_sum);
    sin_f   = fold(ang_r);
    cos_f   = fold(cos_ang);
    px      = close_r ? cur_x_r   : prev_x_r;
    py      = close_r ? cur_y_r   : prev_y_r;
    qx      = close_r ? first_x_r : cur_x_r;
    qy      = close_r ? first_y_r : cur_y_r;
    coord   = CW'(mul_prod);
    p2s     = sprod(mul_prod, psign_r);
    absd    = diff_r[DW-1] ? -diff_r : diff_r;
    div_in  = absd[SH+QW-1:SH];
    sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(div_q);
    cnt_inc = cnt_r + CNT_W'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    ang_nxt        = ang_r;
    last_nxt       = last_r;
    sin_mag_nxt    = sin_mag_r;
    sin_neg_nxt    = sin_neg_r;
    cos_mag_nxt    = cos_mag_r;
    cos_neg_nxt    = cos_neg_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    psign_nxt      = psign_r;
    p1_nxt         = p1_r;
    diff_nxt       = diff_r;
    sum_nxt        = sum_r;
    in_poly_nxt    = in_poly_r;
    cnt_nxt        = cnt_r;
    close_nxt      = close_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    in_tready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          len_nxt   = in_tdata[LEN_W-1:0];
          ang_nxt   = (ang_in >= ANG_FULL) ? ang_in - ANG_FULL : ang_in;
          last_nxt  = in_tlast;
          state_nxt = S_TRIG;
        end
      end
      S_TRIG: begin
        sin_mag_nxt = sin_tab[sin_f.idx];
        sin_neg_nxt = sin_f.neg;
        cos_mag_nxt = sin_tab[cos_f.idx];
        cos_neg_nxt = cos_f.neg;
        state_nxt   = S_CX;
      end
      S_CX: begin
        mul_a = CM'(sin_mag_r);
        mul_b = CM'(len_r);
        if (!mul_st.busy) begin
          mul_start = 1'b1;
          state_nxt = S_CX_W;
        end
      end
      S_CX_W: begin
        if (mul_st.done) begin
          cur_x_nxt = sin_neg_r ? -coord : coord;
          state_nxt = S_CY;
        end
      end
      S_CY: begin
        mul_a = CM'(cos_mag_r);
        mul_b = CM'(len_r);
        if (!mul_st.busy) begin
          mul_start = 1'b1;
          state_nxt = S_CY_W;
        end
      end
      S_CY_W: begin
        if (mul_st.done) begin
          cur_y_nxt = cos_neg_r ? coord : -coord;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        close_nxt = 1'b0;
        if (!in_poly_r) begin
          first_x_nxt = cur_x_r;
          first_y_nxt = cur_y_r;
          sum_nxt     = '0;
          cnt_nxt     = '0;
          in_poly_nxt = 1'b1;
          state_nxt   = S_NEXT;
        end else begin
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        mul_a = mag(px);
        mul_b = mag(qy);
        if (!mul_st.busy) begin
          mul_start = 1'b1;
          psign_nxt = px[CW-1] ^ qy[CW-1];
          state_nxt = S_P1_W;
        end
      end
      S_P1_W: begin
        if (mul_st.done) begin
          p1_nxt    = p2s;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        mul_a = mag(qx);
        mul_b = mag(py);
        if (!mul_st.busy) begin
          mul_start = 1'b1;
          psign_nxt = qx[CW-1] ^ py[CW-1];
          state_nxt = S_P2_W;
        end
      end
      S_P2_W: begin
        if (mul_st.done) begin
          diff_nxt  = {p1_r[PW-1], p1_r} - {p2s[PW-1], p2s};
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        if (!div_st.busy) begin
          div_start = 1'b1;
          state_nxt = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (div_st.done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        sum_nxt   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        state_nxt = close_r ? S_EMIT : S_NEXT;
      end
      S_NEXT: begin
        prev_x_nxt = cur_x_r;
        prev_y_nxt = cur_y_r;
        cnt_nxt    = cnt_inc;
        if (last_r || (cnt_inc >= CNT_W'(MAX_VERTICES))) begin
          close_nxt = 1'b1;
          state_nxt = S_P1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = (sum_r[SUM_W-1:AREA_W] != '0) ? {AREA_W{1'b1}}
                                                         : sum_r[AREA_W-1:0];
          out_tvalid_nxt = 1'b1;
          in_poly_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_poly_r    <= 1'b0;
      cnt_r        <= '0;
      close_r      <= 1'b0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_poly_r    <= in_poly_nxt;
      cnt_r        <= cnt_nxt;
      close_r      <= close_nxt;
      sum_r        <= sum_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    ang_r      <= ang_nxt;
    last_r     <= last_nxt;
    sin_mag_r  <= sin_mag_nxt;
    sin_neg_r  <= sin_neg_nxt;
    cos_mag_r  <= cos_mag_nxt;
    cos_neg_r  <= cos_neg_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    psign_r    <= psign_nxt;
    p1_r       <= p1_nxt;
    diff_r     <= diff_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - AREA_W){1'b0}}, out_data_r};

endmodule

`default_nettype wire

### rtl/core/pga_chk.sv
// Port-level checker for the polar polygon area unit, bound to the top level.
// Depends on pga_pkg for port widths.
`default_nettype none

module pga_chk import pga_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:AREA_W] == '0)
    else $error("result padding not zero");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer taken while a vertex is in work");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while the block was idle");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  logic unused_in;
  assign unused_in = ^{in_tdata, in_tlast};

endmodule

bind polar_polygon_area_unit pga_chk u_pga_chk (.*);

`default_nettype wire
